>>> src/gkm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkm_pkg: shared types, constants and helpers
// Widths, command and status structs, step codes and clamp functions used by
// the Gaussian kernel MMD controller, datapath and divider.
// ----------------------------------------------------------------------------
package gkm_pkg;

  // Sizing
  localparam int MAX_ROWS   = 64;
  localparam int MAX_DIMS   = 16;
  localparam int SET_SIZE   = MAX_ROWS * MAX_DIMS;
  localparam int IDX_W      = $clog2(SET_SIZE);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = IDX_W + 1;
  localparam int ROW_W      = $clog2(MAX_ROWS + 1);
  localparam int DIM_W      = $clog2(MAX_DIMS + 1);

  // Field and register widths
  localparam int ROWCFG_W   = 7;
  localparam int DIMCFG_W   = 5;
  localparam int INV_W      = 24;
  localparam int SAMPLE_W   = 16;
  localparam int MMD_W      = 32;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 32;
  localparam int DIST_W     = SQ_W + $clog2(MAX_DIMS) + 1;
  localparam int DEN_W      = 2 * ROW_W;
  localparam int NUM_W      = SUM_W + 14;
  localparam int DIVCNT_W   = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_X     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_Y     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE  = 8'd3;

  // Kernel micro-steps: one shared multiplier, issue then capture
  localparam logic [3:0] ST_NONE = 4'd0;
  localparam logic [3:0] ST_TLO  = 4'd1;
  localparam logic [3:0] ST_THI  = 4'd2;
  localparam logic [3:0] ST_R2   = 4'd3;
  localparam logic [3:0] ST_R3   = 4'd4;
  localparam logic [3:0] ST_R4   = 4'd5;
  localparam logic [3:0] ST_Q6   = 4'd6;
  localparam logic [3:0] ST_Q24  = 4'd7;
  localparam logic [3:0] ST_P    = 4'd8;

  // Sum / term selection
  localparam logic [1:0] SEL_X  = 2'd0;
  localparam logic [1:0] SEL_Y  = 2'd1;
  localparam logic [1:0] SEL_XY = 2'd2;

  // Arithmetic constants
  localparam logic [34:0] ONE_Q30    = 35'd1 << 30;
  localparam logic [31:0] RECIP_6    = 32'd715827882;   // floor(2^32 / 6)
  localparam logic [31:0] RECIP_24   = 32'd178956970;   // floor(2^32 / 24)
  localparam logic [31:0] T_LIMIT_HI = 32'd12;          // 12.0 in Q.32, upper word
  localparam logic [32:0] ROUND_Q14  = 33'd1 << 13;
  localparam logic [15:0] KERN_MAX   = 16'hFFFF;

  typedef struct packed {
    logic              in_ready;
    logic              rd_en;
    logic              rd_first;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [3:0]        mul_op;
    logic [3:0]        cap_op;
    logic              poly;
    logic              kern_add;
    logic [1:0]        sel;
    logic              div_start;
    logic              div_cap;
    logic              out_load;
  } gkm_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] nx;
    logic [ROW_W-1:0] ny;
    logic [DIM_W-1:0] dims;
    logic             dist_busy;
    logic             t_zero;
    logic             div_busy;
    logic             out_full;
  } gkm_stat_t;

  function automatic logic [ROW_W-1:0] clamp_rows(input logic [ROWCFG_W-1:0] v);
    logic [ROW_W-1:0] res;
    if (v == '0) res = ROW_W'(1);
    else if (32'(v) > MAX_ROWS) res = ROW_W'(MAX_ROWS);
    else res = ROW_W'(v);
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dims(input logic [DIMCFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) res = DIM_W'(1);
    else if (32'(v) > MAX_DIMS) res = DIM_W'(MAX_DIMS);
    else res = DIM_W'(v);
    return res;
  endfunction

endpackage

>>> src/gkm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkm_div: restoring divider
// Unsigned numerator by unsigned denominator, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gkm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gkm_pkg::NUM_W-1:0]  num,
  input  logic [gkm_pkg::DEN_W-1:0]  den,
  output logic                       busy,
  output logic [gkm_pkg::NUM_W-1:0]  quot
);

  logic                          busy_r;
  logic [gkm_pkg::DIVCNT_W-1:0]  cnt_r;
  logic [gkm_pkg::NUM_W-1:0]     quo_r;
  logic [gkm_pkg::DEN_W-1:0]     rem_r;
  logic [gkm_pkg::DEN_W-1:0]     den_r;
  logic [gkm_pkg::DEN_W:0]       rem_sh;
  logic                          ge;
  logic [gkm_pkg::DEN_W:0]       rem_nxt;

  // Shift in the next numerator bit and trial-subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[gkm_pkg::NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= gkm_pkg::DIVCNT_W'(gkm_pkg::NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == gkm_pkg::DIVCNT_W'(1)) busy_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[gkm_pkg::NUM_W-2:0], ge};
      rem_r <= rem_nxt[gkm_pkg::DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

>>> src/gkm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkm_datapath: sample store and arithmetic
// Holds configuration, the sample memory, the distance pipeline, the shared
// kernel multiplier, the kernel sums, the divider and the result register.
// ----------------------------------------------------------------------------
module gkm_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gkm_pkg::gkm_cmd_t               cmd,
  output gkm_pkg::gkm_stat_t              stat,
  input  logic                            in_valid,
  input  logic                            in_op,
  input  logic signed [gkm_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                            in_last_element,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [gkm_pkg::MMD_W-1:0] out_mmd_value,
  input  logic                            cfg_we,
  input  logic [gkm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gkm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration
  logic [gkm_pkg::ROWCFG_W-1:0] rows_x_r, rows_y_r;
  logic [gkm_pkg::DIMCFG_W-1:0] dims_r;
  logic [gkm_pkg::INV_W-1:0]    inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_x_r <= gkm_pkg::ROWCFG_W'(1);
      rows_y_r <= gkm_pkg::ROWCFG_W'(1);
      dims_r   <= gkm_pkg::DIMCFG_W'(1);
      inv_r    <= gkm_pkg::INV_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        gkm_pkg::CFG_ROWS_X:     rows_x_r <= cfg_data[gkm_pkg::ROWCFG_W-1:0];
        gkm_pkg::CFG_ROWS_Y:     rows_y_r <= cfg_data[gkm_pkg::ROWCFG_W-1:0];
        gkm_pkg::CFG_DIMENSIONS: dims_r   <= cfg_data[gkm_pkg::DIMCFG_W-1:0];
        gkm_pkg::CFG_INV_SCALE:  inv_r    <= cfg_data[gkm_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  logic [gkm_pkg::ROW_W-1:0] nx, ny;
  assign nx = gkm_pkg::clamp_rows(rows_x_r);
  assign ny = gkm_pkg::clamp_rows(rows_y_r);

  // Load counters and store writes
  logic                         accept;
  logic [gkm_pkg::CNT_W-1:0]    idx_x_r, idx_y_r;
  logic                         wr_en;
  logic [gkm_pkg::ADDR_W-1:0]   wr_addr;

  assign accept = in_valid && cmd.in_ready;

  always_comb begin
    if (!in_op) begin
      wr_en   = accept && (32'(idx_x_r) < gkm_pkg::SET_SIZE);
      wr_addr = {1'b0, idx_x_r[gkm_pkg::IDX_W-1:0]};
    end else begin
      wr_en   = accept && (32'(idx_y_r) < gkm_pkg::SET_SIZE);
      wr_addr = {1'b1, idx_y_r[gkm_pkg::IDX_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_x_r <= '0;
      idx_y_r <= '0;
    end else if (accept && in_last_element) begin
      idx_x_r <= '0;
      idx_y_r <= '0;
    end else if (wr_en) begin
      if (!in_op) idx_x_r <= idx_x_r + 1'b1;
      else        idx_y_r <= idx_y_r + 1'b1;
    end
  end

  // Sample store: one write port, two registered read ports
  logic signed [gkm_pkg::SAMPLE_W-1:0] mem [2**gkm_pkg::ADDR_W];
  logic signed [gkm_pkg::SAMPLE_W-1:0] rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_sample_value;
    rd_a_r <= mem[cmd.rd_addr_a];
    rd_b_r <= mem[cmd.rd_addr_b];
  end

  // Distance pipeline: read, square, accumulate
  logic                          v1_r, f1_r, v2_r, f2_r;
  logic signed [gkm_pkg::SAMPLE_W:0] diff;
  logic [gkm_pkg::SAMPLE_W-1:0]  mag;
  logic [gkm_pkg::SQ_W-1:0]      sq_r;
  logic [gkm_pkg::DIST_W-1:0]    acc_d_r;

  always_comb begin
    diff = (gkm_pkg::SAMPLE_W+1)'(rd_a_r) - (gkm_pkg::SAMPLE_W+1)'(rd_b_r);
    mag  = diff[gkm_pkg::SAMPLE_W] ? gkm_pkg::SAMPLE_W'(-diff)
                                   : diff[gkm_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_r <= cmd.rd_first;
    f2_r <= f1_r;
    sq_r <= mag * mag;
    if (v2_r) begin
      acc_d_r <= f2_r ? gkm_pkg::DIST_W'(sq_r) : acc_d_r + gkm_pkg::DIST_W'(sq_r);
    end
  end

  // Shared kernel multiplier with registered product
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;
  logic [63:0] tlo_r;
  logic [31:0] r_r, r2_r, r3_r, r4_r, q6_r, q24_r, p_r;
  logic        t_zero_r;

  always_comb begin
    case (cmd.mul_op)
      gkm_pkg::ST_TLO: begin
        mul_a = acc_d_r[31:0];
        mul_b = 32'(inv_r);
      end
      gkm_pkg::ST_THI: begin
        mul_a = 32'(acc_d_r[gkm_pkg::DIST_W-1:32]);
        mul_b = 32'(inv_r);
      end
      gkm_pkg::ST_R2: begin
        mul_a = r_r;
        mul_b = r_r;
      end
      gkm_pkg::ST_R3: begin
        mul_a = r2_r;
        mul_b = r_r;
      end
      gkm_pkg::ST_R4: begin
        mul_a = r3_r;
        mul_b = r_r;
      end
      gkm_pkg::ST_Q6: begin
        mul_a = r3_r;
        mul_b = gkm_pkg::RECIP_6;
      end
      gkm_pkg::ST_Q24: begin
        mul_a = r4_r;
        mul_b = gkm_pkg::RECIP_24;
      end
      gkm_pkg::ST_P: begin
        mul_a = p_r;
        mul_b = p_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != gkm_pkg::ST_NONE) prod_r <= mul_a * mul_b;
  end

  // Capture results of the multiplier
  logic [63:0] t64;
  logic [31:0] q_est;
  logic [34:0] q6x, rem6;
  logic [35:0] q24x, rem24;
  logic [34:0] poly;

  always_comb begin
    t64   = {prod_r[31:0], 32'b0} + tlo_r;
    q_est = prod_r[63:32];
    q6x   = {1'b0, q_est, 2'b0} + {2'b0, q_est, 1'b0};
    rem6  = {3'b0, r3_r} - q6x;
    q24x  = {q_est, 4'b0} + {1'b0, q_est, 3'b0};
    rem24 = {4'b0, r4_r} - q24x;
    poly  = gkm_pkg::ONE_Q30 - {3'b0, r_r} + {4'b0, r2_r[31:1]}
            - {3'b0, q6_r} + {3'b0, q24_r};
  end

  always_ff @(posedge clk) begin
    case (cmd.cap_op)
      gkm_pkg::ST_TLO: tlo_r <= prod_r;
      gkm_pkg::ST_THI: begin
        t_zero_r <= t64[63:32] >= gkm_pkg::T_LIMIT_HI;
        r_r      <= {6'b0, t64[35:10]};
      end
      gkm_pkg::ST_R2:  r2_r <= prod_r[61:30];
      gkm_pkg::ST_R3:  r3_r <= prod_r[61:30];
      gkm_pkg::ST_R4:  r4_r <= prod_r[61:30];
      // Correct the reciprocal estimate by at most one
      gkm_pkg::ST_Q6:  q6_r  <= (rem6 >= 35'd6) ? q_est + 1'b1 : q_est;
      gkm_pkg::ST_Q24: q24_r <= (rem24 >= 36'd24) ? q_est + 1'b1 : q_est;
      gkm_pkg::ST_P:   p_r <= prod_r[61:30];
      default: ;
    endcase
    if (cmd.poly) p_r <= poly[31:0];
  end

  // Kernel value and sums
  logic [32:0] pk;
  logic [15:0] kern;
  logic [gkm_pkg::SUM_W-1:0] sum_x_r, sum_y_r, sum_xy_r;

  always_comb begin
    pk = (33'(p_r) + gkm_pkg::ROUND_Q14) >> 14;
    if (t_zero_r)             kern = '0;
    else if (pk > 33'(gkm_pkg::KERN_MAX)) kern = gkm_pkg::KERN_MAX;
    else                      kern = pk[15:0];
  end

  logic clr_sums;
  assign clr_sums = accept && in_last_element;

  always_ff @(posedge clk) begin
    if (!rst_n || clr_sums) begin
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_xy_r <= '0;
    end else if (cmd.kern_add) begin
      case (cmd.sel)
        gkm_pkg::SEL_X:  sum_x_r  <= sum_x_r  + gkm_pkg::SUM_W'(kern);
        gkm_pkg::SEL_Y:  sum_y_r  <= sum_y_r  + gkm_pkg::SUM_W'(kern);
        gkm_pkg::SEL_XY: sum_xy_r <= sum_xy_r + gkm_pkg::SUM_W'(kern);
        default: ;
      endcase
    end
  end

  // Scaling divisions
  logic [gkm_pkg::DEN_W-1:0] den_x, den_y, den_xy, div_den;
  logic [gkm_pkg::NUM_W-1:0] div_num, div_quot;
  logic                      div_busy;
  logic [31:0]               tx_r, ty_r, txy_r;

  always_comb begin
    den_x  = gkm_pkg::DEN_W'(nx) * gkm_pkg::DEN_W'(nx - 1'b1);
    den_y  = gkm_pkg::DEN_W'(ny) * gkm_pkg::DEN_W'(ny - 1'b1);
    den_xy = gkm_pkg::DEN_W'(nx) * gkm_pkg::DEN_W'(ny);
    case (cmd.sel)
      gkm_pkg::SEL_X: begin
        div_den = den_x;
        div_num = {sum_x_r, 14'b0} + gkm_pkg::NUM_W'(den_x >> 1);
      end
      gkm_pkg::SEL_Y: begin
        div_den = den_y;
        div_num = {sum_y_r, 14'b0} + gkm_pkg::NUM_W'(den_y >> 1);
      end
      default: begin
        div_den = den_xy;
        div_num = {1'b0, sum_xy_r, 13'b0} + gkm_pkg::NUM_W'(den_xy >> 1);
      end
    endcase
  end

  gkm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || clr_sums) begin
      tx_r  <= '0;
      ty_r  <= '0;
      txy_r <= '0;
    end else if (cmd.div_cap) begin
      case (cmd.sel)
        gkm_pkg::SEL_X:  tx_r  <= div_quot[31:0];
        gkm_pkg::SEL_Y:  ty_r  <= div_quot[31:0];
        gkm_pkg::SEL_XY: txy_r <= div_quot[31:0];
        default: ;
      endcase
    end
  end

  // Combine terms, saturate and hold the result until taken
  logic signed [34:0] m;
  logic signed [gkm_pkg::MMD_W-1:0] m_sat;
  logic out_valid_r;
  logic signed [gkm_pkg::MMD_W-1:0] out_mmd_r;

  always_comb begin
    m = $signed({3'b0, tx_r}) + $signed({3'b0, ty_r}) - $signed({2'b0, txy_r, 1'b0});
    if (m > 35'sd2147483647)       m_sat = 32'sh7FFFFFFF;
    else if (m < -35'sd2147483648) m_sat = 32'sh80000000;
    else                           m_sat = m[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_mmd_r <= m_sat;
  end

  assign out_valid     = out_valid_r;
  assign out_mmd_value = out_mmd_r;

  always_comb begin
    stat.nx        = nx;
    stat.ny        = ny;
    stat.dims      = gkm_pkg::clamp_dims(dims_r);
    stat.dist_busy = v1_r || v2_r;
    stat.t_zero    = t_zero_r;
    stat.div_busy  = div_busy;
    stat.out_full  = out_valid_r;
  end

  // Checks
  a_mul_after_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_op != gkm_pkg::ST_NONE) |-> !(v1_r || v2_r))
    else $error("kernel multiply overlaps distance pipeline");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ready)
    else $error("result overwritten before taken");
  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_element) |=> (idx_x_r == '0 && idx_y_r == '0))
    else $error("load counters not cleared after last element");

endmodule

>>> src/gkm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkm_ctrl: sequencing controller
// Walks the pair loops of each phase, steps the kernel micro-sequence and
// the scaling divisions, and hands the result to the output register.
// ----------------------------------------------------------------------------
module gkm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_element,
  input  gkm_pkg::gkm_stat_t  stat,
  output gkm_pkg::gkm_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PHASE    = 4'd1;
  localparam logic [3:0] S_DIST     = 4'd2;
  localparam logic [3:0] S_WAIT     = 4'd3;
  localparam logic [3:0] S_MUL      = 4'd4;
  localparam logic [3:0] S_CAP      = 4'd5;
  localparam logic [3:0] S_POLY     = 4'd6;
  localparam logic [3:0] S_KERN     = 4'd7;
  localparam logic [3:0] S_FIN_GO   = 4'd8;
  localparam logic [3:0] S_FIN_WAIT = 4'd9;
  localparam logic [3:0] S_FIN_CAP  = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  logic [3:0]                 state_r, state_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic [gkm_pkg::ROW_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [gkm_pkg::DIM_W-1:0]  c_r, c_nxt;
  logic [gkm_pkg::IDX_W-1:0]  bi_r, bi_nxt, bj_r, bj_nxt;
  logic [3:0]                 step_r, step_nxt;
  logic [2:0]                 pc_r, pc_nxt;

  logic [gkm_pkg::ROW_W-1:0]  n_a, n_b;
  logic [gkm_pkg::IDX_W-1:0]  dims_i;
  logic                       set_a, set_b, same_set;

  always_comb begin
    same_set = phase_r != gkm_pkg::SEL_XY;
    set_a    = phase_r == gkm_pkg::SEL_Y;
    set_b    = phase_r != gkm_pkg::SEL_X;
    n_a      = (phase_r == gkm_pkg::SEL_Y) ? stat.ny : stat.nx;
    n_b      = same_set ? n_a : stat.ny;
    dims_i   = gkm_pkg::IDX_W'(stat.dims);
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    c_nxt     = c_r;
    bi_nxt    = bi_r;
    bj_nxt    = bj_r;
    step_nxt  = step_r;
    pc_nxt    = pc_r;
    cmd       = '0;
    cmd.sel   = phase_r;
    cmd.rd_addr_a = {set_a, bi_r + gkm_pkg::IDX_W'(c_r)};
    cmd.rd_addr_b = {set_b, bj_r + gkm_pkg::IDX_W'(c_r)};

    case (state_r)
      // Take samples until the last one
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid && in_last_element) begin
          phase_nxt = gkm_pkg::SEL_X;
          state_nxt = S_PHASE;
        end
      end
      // Set up the pair loop of a phase, skip sets without pairs
      S_PHASE: begin
        c_nxt  = '0;
        i_nxt  = '0;
        bi_nxt = '0;
        if (phase_r == gkm_pkg::SEL_XY) begin
          j_nxt     = '0;
          bj_nxt    = '0;
          state_nxt = S_DIST;
        end else if (n_a < gkm_pkg::ROW_W'(2)) begin
          phase_nxt = phase_r + 1'b1;
        end else begin
          j_nxt     = gkm_pkg::ROW_W'(1);
          bj_nxt    = dims_i;
          state_nxt = S_DIST;
        end
      end
      // Issue one dimension per cycle
      S_DIST: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = c_r == '0;
        if (c_r == stat.dims - 1'b1) begin
          c_nxt     = '0;
          state_nxt = S_WAIT;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      S_WAIT: begin
        if (!stat.dist_busy) begin
          step_nxt  = gkm_pkg::ST_TLO;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (step_r == gkm_pkg::ST_R2 && stat.t_zero) begin
          state_nxt = S_KERN;
        end else begin
          cmd.mul_op = step_r;
          state_nxt  = S_CAP;
        end
      end
      S_CAP: begin
        cmd.cap_op = step_r;
        state_nxt  = S_MUL;
        case (step_r)
          gkm_pkg::ST_TLO: step_nxt = gkm_pkg::ST_THI;
          gkm_pkg::ST_THI: step_nxt = gkm_pkg::ST_R2;
          gkm_pkg::ST_R2:  step_nxt = gkm_pkg::ST_R3;
          gkm_pkg::ST_R3:  step_nxt = gkm_pkg::ST_R4;
          gkm_pkg::ST_R4:  step_nxt = gkm_pkg::ST_Q6;
          gkm_pkg::ST_Q6:  step_nxt = gkm_pkg::ST_Q24;
          gkm_pkg::ST_Q24: state_nxt = S_POLY;
          gkm_pkg::ST_P: begin
            if (pc_r == 3'd7) state_nxt = S_KERN;
            else pc_nxt = pc_r + 1'b1;
          end
          default: state_nxt = S_KERN;
        endcase
      end
      // Form the series, then square it eight times
      S_POLY: begin
        cmd.poly  = 1'b1;
        step_nxt  = gkm_pkg::ST_P;
        pc_nxt    = '0;
        state_nxt = S_MUL;
      end
      // Add the kernel value and advance to the next pair
      S_KERN: begin
        cmd.kern_add = 1'b1;
        state_nxt    = S_DIST;
        if ((gkm_pkg::ROW_W+1)'(j_r) + 1'b1 < (gkm_pkg::ROW_W+1)'(n_b)) begin
          j_nxt  = j_r + 1'b1;
          bj_nxt = bj_r + dims_i;
        end else if (same_set &&
                     (gkm_pkg::ROW_W+1)'(i_r) + 2'd2 < (gkm_pkg::ROW_W+1)'(n_a)) begin
          i_nxt  = i_r + 1'b1;
          j_nxt  = i_r + 2'd2;
          bi_nxt = bi_r + dims_i;
          bj_nxt = bi_r + dims_i + dims_i;
        end else if (!same_set &&
                     (gkm_pkg::ROW_W+1)'(i_r) + 1'b1 < (gkm_pkg::ROW_W+1)'(n_a)) begin
          i_nxt  = i_r + 1'b1;
          j_nxt  = '0;
          bi_nxt = bi_r + dims_i;
          bj_nxt = '0;
        end else if (same_set) begin
          phase_nxt = phase_r + 1'b1;
          state_nxt = S_PHASE;
        end else begin
          phase_nxt = gkm_pkg::SEL_X;
          state_nxt = S_FIN_GO;
        end
      end
      // Scale each sum; terms of single-row sets stay zero
      S_FIN_GO: begin
        if (phase_r != gkm_pkg::SEL_XY && n_a < gkm_pkg::ROW_W'(2)) begin
          phase_nxt = phase_r + 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_FIN_WAIT;
        end
      end
      S_FIN_WAIT: begin
        if (!stat.div_busy) state_nxt = S_FIN_CAP;
      end
      S_FIN_CAP: begin
        cmd.div_cap = 1'b1;
        if (phase_r == gkm_pkg::SEL_XY) begin
          state_nxt = S_OUT;
        end else begin
          phase_nxt = phase_r + 1'b1;
          state_nxt = S_FIN_GO;
        end
      end
      // Hold until the output register is free
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= gkm_pkg::SEL_X;
      step_r  <= gkm_pkg::ST_NONE;
      pc_r    <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      pc_r    <= pc_nxt;
      c_r     <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    bi_r <= bi_nxt;
    bj_r <= bj_nxt;
  end

endmodule

>>> src/gaussian_kernel_mmd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_kernel_mmd: unbiased squared MMD with a Gaussian kernel
// Loads sets X and Y into a sample store, then evaluates all row pairs.
// Load: one element per cycle; the last element starts the computation.
// Compute: each row pair goes through the distance pipeline and the shared
//   kernel multiplier (the later steps are skipped when the kernel is cut to zero),
//   then up to three divisions follow; input is held off until the
//   result goes to the output register.
// Reset (rst_n low, synchronous) clears control, counters and sums; the
//   sample store is not cleared.
// ----------------------------------------------------------------------------
module gaussian_kernel_mmd (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic signed [gkm_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic                                 in_last_element,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [gkm_pkg::MMD_W-1:0]     out_mmd_value,
  input  logic                                 cfg_we,
  input  logic [gkm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gkm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  gkm_pkg::gkm_cmd_t  cmd;
  gkm_pkg::gkm_stat_t stat;

  gkm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_valid        (in_valid),
    .in_op           (in_op),
    .in_sample_value (in_sample_value),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mmd_value   (out_mmd_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  gkm_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_element (in_last_element),
    .stat            (stat),
    .cmd             (cmd)
  );

  assign in_ready = cmd.in_ready;

endmodule
